[rtl/assert_macros.svh]
// Assertion helpers; every use samples on clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tcr_pkg.sv]
package tcr_pkg;

    localparam logic [2:0] REG_TARGET_RED        = 3'd0;
    localparam logic [2:0] REG_TARGET_GREEN      = 3'd1;
    localparam logic [2:0] REG_TARGET_BLUE       = 3'd2;
    localparam logic [2:0] REG_REPLACEMENT_RED   = 3'd3;
    localparam logic [2:0] REG_REPLACEMENT_GREEN = 3'd4;
    localparam logic [2:0] REG_REPLACEMENT_BLUE  = 3'd5;
    localparam logic [2:0] REG_GRAY_TOLERANCE    = 3'd6;
    localparam logic [2:0] REG_HUE_TOLERANCE     = 3'd7;

    localparam logic [1:0] HUE_ZERO = 2'd0;
    localparam logic [1:0] HUE_POS  = 2'd1;
    localparam logic [1:0] HUE_OFF  = 2'd2;

    localparam logic [7:0] HUE_THIRD    = 8'd85;
    localparam logic [7:0] GRAY_TOL_OFF = 8'd255;
    localparam logic [6:0] HUE_TOL_ANY  = 7'd127;
    // floor(x / 100) == (x * 5243) >> 19 for every luma sum below 43690.
    localparam logic [27:0] RECIP_100   = 28'd5243;

    typedef struct packed {
        logic [14:0] num;
        logic [8:0]  den;
        logic [1:0]  kind;
    } hue_setup_t;

    typedef struct packed {
        logic [14:0] rem;
        logic [8:0]  den;
        logic [6:0]  q;
        logic [1:0]  kind;
    } hue_div_t;

    typedef struct packed {
        logic [22:0] rem;
        logic [7:0]  q;
        logic        sat;
    } scl_t;

    function automatic logic [14:0] mul85(input logic [7:0] x);
        mul85 = 15'(x) * 15'(HUE_THIRD);
    endfunction

    function automatic logic [14:0] luma_sum(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
        luma_sum = 15'(r) * 15'd30 + 15'(g) * 15'd59 + 15'(b) * 15'd11;
    endfunction

    // One restoring-division step of the hue quotient.
    function automatic hue_div_t hue_step(input hue_div_t h, input logic [2:0] i);
        logic [15:0] dsh;
        logic [15:0] rem;
        dsh = {7'd0, h.den} << i;
        rem = {1'b0, h.rem};
        hue_step = h;
        if (rem >= dsh)
        begin
            hue_step.rem = 15'(rem - dsh);
            hue_step.q[i] = 1'b1;
        end
    endfunction

    // One restoring-division step of the luma scaling quotient.
    function automatic scl_t scl_step(input scl_t s, input logic [14:0] tsum,
                                      input logic [2:0] i);
        logic [22:0] dsh;
        dsh = {8'd0, tsum} << i;
        scl_step = s;
        if (s.rem >= dsh)
        begin
            scl_step.rem = s.rem - dsh;
            scl_step.q[i] = 1'b1;
        end
    endfunction

endpackage

[rtl/tolerant_color_replace.sv]
// Channel   | Handshake                  | Payload
// ----------+----------------------------+-------------------------------------------
// pixel     | pixel_valid / pixel_ready  | pixel_red, pixel_green, pixel_blue
// result    | result_valid / result_ready| out_red, out_green, out_blue, replaced
// config    | cfg_we                     | cfg_index, cfg_data
//
// One pixel per cycle while result_ready keeps the pipe moving; the depth is set
// by the two restoring dividers (hue code and luma scaling) spread over the stages.
// rst_n clears the valid bits and all configuration registers to zero.
// Each stage holds its beat while the next one is full and held, so bubbles close up;
// a pixel is still taken while a result waits on result_ready, until every stage is full.
`include "assert_macros.svh"

module tolerant_color_replace import tcr_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       pixel_valid,
    output logic       pixel_ready,
    input  logic [7:0] pixel_red,
    input  logic [7:0] pixel_green,
    input  logic [7:0] pixel_blue,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output logic       replaced
);

    typedef struct packed {
        logic [23:0] pix;
        logic [14:0] psum;
        logic [14:0] lsum;
        logic [14:0] tsum;
        hue_setup_t  hp;
        hue_setup_t  ht;
        logic        pgray;
        logic        tgray;
    } s1_t;

    typedef struct packed {
        logic [23:0] pix;
        logic [22:0] prod_r;
        logic [22:0] prod_g;
        logic [22:0] prod_b;
        logic [7:0]  gray;
        logic [7:0]  tluma;
        logic [14:0] tsum;
        hue_div_t    dp;
        hue_div_t    dt;
        logic        pgray;
        logic        tgray;
    } s2_t;

    typedef struct packed {
        logic [23:0] pix;
        scl_t        sr;
        scl_t        sg;
        scl_t        sb;
        logic [14:0] tsum;
        hue_div_t    dp;
        hue_div_t    dt;
        logic        luma_ok;
        logic        pgray;
        logic        tgray;
    } sdiv_t;

    logic [7:0] target_red_reg, target_green_reg, target_blue_reg;
    logic [7:0] replacement_red_reg, replacement_green_reg, replacement_blue_reg;
    logic [7:0] gray_tolerance_reg;
    logic [6:0] hue_tolerance_reg;

    logic [5:0] v_reg, v_next;
    logic [5:0] rdy;

    s1_t   s1_reg, s1_next;
    s2_t   s2_reg, s2_next;
    sdiv_t s3_reg, s3_next;
    sdiv_t s4_reg, s4_next;
    sdiv_t s5_reg, s5_next;
    logic [24:0] out_reg, out_next;

    hue_setup_t hp_setup, ht_setup;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_red_reg        <= '0;
            target_green_reg      <= '0;
            target_blue_reg       <= '0;
            replacement_red_reg   <= '0;
            replacement_green_reg <= '0;
            replacement_blue_reg  <= '0;
            gray_tolerance_reg    <= '0;
            hue_tolerance_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TARGET_RED:        target_red_reg        <= cfg_data;
                REG_TARGET_GREEN:      target_green_reg      <= cfg_data;
                REG_TARGET_BLUE:       target_blue_reg       <= cfg_data;
                REG_REPLACEMENT_RED:   replacement_red_reg   <= cfg_data;
                REG_REPLACEMENT_GREEN: replacement_green_reg <= cfg_data;
                REG_REPLACEMENT_BLUE:  replacement_blue_reg  <= cfg_data;
                REG_GRAY_TOLERANCE:    gray_tolerance_reg    <= cfg_data;
                REG_HUE_TOLERANCE:     hue_tolerance_reg     <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // A stage can take a beat when it is empty or its beat moves on this cycle.
    always_comb
    begin
        rdy[5] = !v_reg[5] || result_ready;
        for (int k = 4; k >= 0; k--)
            rdy[k] = !v_reg[k] || rdy[k + 1];
        v_next[0] = rdy[0] ? pixel_valid : v_reg[0];
        for (int k = 1; k < 6; k++)
            v_next[k] = rdy[k] ? v_reg[k - 1] : v_reg[k];
    end

    assign pixel_ready  = rdy[0];
    assign result_valid = v_reg[5];

    tcr_hue_setup u_hue_pixel (
        .red   (pixel_red),
        .green (pixel_green),
        .blue  (pixel_blue),
        .setup (hp_setup)
    );

    tcr_hue_setup u_hue_target (
        .red   (target_red_reg),
        .green (target_green_reg),
        .blue  (target_blue_reg),
        .setup (ht_setup)
    );

    // Stage 1: weighted sums and hue divider operands.
    always_comb
    begin
        s1_next.pix   = {pixel_red, pixel_green, pixel_blue};
        s1_next.lsum  = luma_sum(pixel_red, pixel_green, pixel_blue);
        s1_next.psum  = s1_next.lsum + 15'd1;
        s1_next.tsum  = luma_sum(target_red_reg, target_green_reg, target_blue_reg) + 15'd1;
        s1_next.hp    = hp_setup;
        s1_next.ht    = ht_setup;
        s1_next.pgray = (pixel_red == pixel_green) && (pixel_red == pixel_blue);
        s1_next.tgray = (target_red_reg == target_green_reg) &&
                        (target_red_reg == target_blue_reg);
    end

    // Stage 2: products, lumas, first two hue quotient bits.
    always_comb
    begin
        logic [27:0] lp;
        logic [27:0] lt;
        hue_div_t    ip;
        hue_div_t    it;
        lp = 28'(s1_reg.lsum) * RECIP_100;
        lt = 28'(s1_reg.tsum) * RECIP_100;
        ip = '{rem: s1_reg.hp.num, den: s1_reg.hp.den, q: 7'd0, kind: s1_reg.hp.kind};
        it = '{rem: s1_reg.ht.num, den: s1_reg.ht.den, q: 7'd0, kind: s1_reg.ht.kind};
        s2_next.pix    = s1_reg.pix;
        s2_next.prod_r = 23'(replacement_red_reg) * 23'(s1_reg.psum);
        s2_next.prod_g = 23'(replacement_green_reg) * 23'(s1_reg.psum);
        s2_next.prod_b = 23'(replacement_blue_reg) * 23'(s1_reg.psum);
        s2_next.gray   = lp[26:19];
        s2_next.tluma  = lt[26:19];
        s2_next.tsum   = s1_reg.tsum;
        s2_next.dp     = hue_step(hue_step(ip, 3'd6), 3'd5);
        s2_next.dt     = hue_step(hue_step(it, 3'd6), 3'd5);
        s2_next.pgray  = s1_reg.pgray;
        s2_next.tgray  = s1_reg.tgray;
    end

    // Stage 3: luma window, saturation test, top scaling bits, hue bits four and three.
    always_comb
    begin
        logic [8:0] hi;
        logic [8:0] lo;
        scl_t       ir, ig, ib;
        hi = {1'b0, s2_reg.tluma} + {1'b0, gray_tolerance_reg};
        lo = {1'b0, s2_reg.gray} + {1'b0, gray_tolerance_reg};
        ir = '{rem: s2_reg.prod_r, q: 8'd0, sat: s2_reg.prod_r >= {s2_reg.tsum, 8'd0}};
        ig = '{rem: s2_reg.prod_g, q: 8'd0, sat: s2_reg.prod_g >= {s2_reg.tsum, 8'd0}};
        ib = '{rem: s2_reg.prod_b, q: 8'd0, sat: s2_reg.prod_b >= {s2_reg.tsum, 8'd0}};
        s3_next.pix     = s2_reg.pix;
        s3_next.tsum    = s2_reg.tsum;
        s3_next.sr      = scl_step(scl_step(ir, s2_reg.tsum, 3'd7), s2_reg.tsum, 3'd6);
        s3_next.sg      = scl_step(scl_step(ig, s2_reg.tsum, 3'd7), s2_reg.tsum, 3'd6);
        s3_next.sb      = scl_step(scl_step(ib, s2_reg.tsum, 3'd7), s2_reg.tsum, 3'd6);
        s3_next.dp      = hue_step(hue_step(s2_reg.dp, 3'd4), 3'd3);
        s3_next.dt      = hue_step(hue_step(s2_reg.dt, 3'd4), 3'd3);
        s3_next.luma_ok = (gray_tolerance_reg == GRAY_TOL_OFF) ||
                          !(({1'b0, s2_reg.gray} > hi) || (lo < {1'b0, s2_reg.tluma}));
        s3_next.pgray   = s2_reg.pgray;
        s3_next.tgray   = s2_reg.tgray;
    end

    // Stage 4: middle scaling bits, hue bits two and one.
    always_comb
    begin
        s4_next    = s3_reg;
        s4_next.sr = scl_step(scl_step(scl_step(s3_reg.sr, s3_reg.tsum, 3'd5),
                                       s3_reg.tsum, 3'd4), s3_reg.tsum, 3'd3);
        s4_next.sg = scl_step(scl_step(scl_step(s3_reg.sg, s3_reg.tsum, 3'd5),
                                       s3_reg.tsum, 3'd4), s3_reg.tsum, 3'd3);
        s4_next.sb = scl_step(scl_step(scl_step(s3_reg.sb, s3_reg.tsum, 3'd5),
                                       s3_reg.tsum, 3'd4), s3_reg.tsum, 3'd3);
        s4_next.dp = hue_step(hue_step(s3_reg.dp, 3'd2), 3'd1);
        s4_next.dt = hue_step(hue_step(s3_reg.dt, 3'd2), 3'd1);
    end

    // Stage 5: last scaling bits and last hue bit.
    always_comb
    begin
        s5_next    = s4_reg;
        s5_next.sr = scl_step(scl_step(scl_step(s4_reg.sr, s4_reg.tsum, 3'd2),
                                       s4_reg.tsum, 3'd1), s4_reg.tsum, 3'd0);
        s5_next.sg = scl_step(scl_step(scl_step(s4_reg.sg, s4_reg.tsum, 3'd2),
                                       s4_reg.tsum, 3'd1), s4_reg.tsum, 3'd0);
        s5_next.sb = scl_step(scl_step(scl_step(s4_reg.sb, s4_reg.tsum, 3'd2),
                                       s4_reg.tsum, 3'd1), s4_reg.tsum, 3'd0);
        s5_next.dp = hue_step(s4_reg.dp, 3'd0);
        s5_next.dt = hue_step(s4_reg.dt, 3'd0);
    end

    // Output stage: hue codes, wrapped hue window and the final select.
    always_comb
    begin
        logic [7:0] hp;
        logic [7:0] ht;
        logic [7:0] up;
        logic [7:0] down;
        logic       win;
        logic       match;
        case (s5_reg.dp.kind)
            HUE_POS: hp = {1'b0, s5_reg.dp.q};
            HUE_OFF: hp = HUE_THIRD + {1'b0, s5_reg.dp.q};
            default: hp = 8'd0;
        endcase
        case (s5_reg.dt.kind)
            HUE_POS: ht = {1'b0, s5_reg.dt.q};
            HUE_OFF: ht = HUE_THIRD + {1'b0, s5_reg.dt.q};
            default: ht = 8'd0;
        endcase
        up   = hp + {1'b0, hue_tolerance_reg};
        down = hp - {1'b0, hue_tolerance_reg};
        if ($signed(up) > $signed(down))
            win = ($signed(ht) > $signed(down)) && ($signed(ht) < $signed(up));
        else
            win = ($signed(ht) > $signed(down)) || ($signed(ht) < $signed(up));
        match = s5_reg.luma_ok && ((hue_tolerance_reg == HUE_TOL_ANY) ||
                                   s5_reg.pgray || s5_reg.tgray || win);
        if (match)
            out_next = {s5_reg.sr.sat ? 8'hFF : s5_reg.sr.q,
                        s5_reg.sg.sat ? 8'hFF : s5_reg.sg.q,
                        s5_reg.sb.sat ? 8'hFF : s5_reg.sb.q, 1'b1};
        else
            out_next = {s5_reg.pix, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
            s1_reg <= s1_next;
        if (rdy[1])
            s2_reg <= s2_next;
        if (rdy[2])
            s3_reg <= s3_next;
        if (rdy[3])
            s4_reg <= s4_next;
        if (rdy[4])
            s5_reg <= s5_next;
        if (rdy[5])
            out_reg <= out_next;
    end

    assign out_red   = out_reg[24:17];
    assign out_green = out_reg[16:9];
    assign out_blue  = out_reg[8:1];
    assign replaced  = out_reg[0];

    `ASSERT_SAME(a_ready_when_drained, result_ready, pixel_ready,
                 "pixel_ready low although result_ready is high")
    `ASSERT_SAME(a_full_stalls_input, (v_reg == 6'h3F) && !result_ready, !pixel_ready,
                 "pixel accepted into a full stalled pipeline")
    `ASSERT_NEXT(a_result_holds, result_valid && !result_ready,
                 result_valid && $stable(out_reg), "waiting result changed")
    `ASSERT_SAME(a_hue_range, v_reg[4] && (s5_reg.dp.kind != HUE_ZERO),
                 s5_reg.dp.q <= HUE_THIRD[6:0], "pixel hue quotient above 85")

endmodule

[rtl/tcr_hue_setup.sv]
module tcr_hue_setup import tcr_pkg::*; (
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output hue_setup_t setup
);

    logic [7:0] a;
    logic [7:0] c;

    assign a = red - green;
    assign c = blue - green;

    always_comb
    begin
        setup = '0;
        setup.kind = HUE_ZERO;
        if (green >= red && green <= blue)
        begin
            // Here blue is never below red; equal ends give hue zero.
            if (red != blue)
            begin
                setup.num  = mul85(blue - red);
                setup.den  = {1'b0, green - red} + {1'b0, blue - red};
                setup.kind = HUE_POS;
            end
        end
        else
        begin
            setup.num = mul85(a);
            setup.den = {1'b0, a} + {1'b0, c};
            setup.kind = (setup.den == 9'd0) ? HUE_ZERO : HUE_OFF;
        end
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import tcr_pkg::*;

    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       rep;
    } color_t;

    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        bit         typed;
        color_t     want;
    } pixel_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;
    logic       pixel_valid;
    logic       pixel_ready;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic       result_valid;
    logic       result_ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       replaced;

    // Shadow copy of the block's configuration registers.
    logic [7:0] tgt_r, tgt_g, tgt_b, rep_r, rep_g, rep_b, gray_tol;
    logic [6:0] hue_tol;

    color_t pending_colors[$];
    int     errors;
    int     quiet_cycles;
    bit     hold_long;
    bit     no_idle;

    tolerant_color_replace uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .pixel_valid(pixel_valid), .pixel_ready(pixel_ready),
        .pixel_red(pixel_red), .pixel_green(pixel_green), .pixel_blue(pixel_blue),
        .result_valid(result_valid), .result_ready(result_ready),
        .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
        .replaced(replaced)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int to_sbyte(input int v);
        int u;
        u = v & 255;
        return (u >= 128) ? u - 256 : u;
    endfunction

    function automatic int crude_hue(input int r, input int g, input int b);
        int a;
        int c;
        if (g >= r && g <= b)
        begin
            if (r == b)
                return 0;
            if (b > r)
                return (85 * (b - r)) / ((g - r) + (b - r));
            return -((85 * (r - b)) / ((g - b) + (r - b)));
        end
        a = (r - g) & 255;
        c = (b - g) & 255;
        if (a + c == 0)
            return 0;
        return to_sbyte(85 + (a * 85) / (a + c));
    endfunction

    function automatic bit color_matches(input int r, input int g, input int b, input int tsum);
        int gt;
        int ht;
        int luma;
        int tl;
        int mid;
        int h;
        int up;
        int down;
        gt = gray_tol;
        ht = hue_tol;
        if (gt == 255 && ht >= 127)
            return 1;
        if (gt != 255)
        begin
            luma = (r * 30 + g * 59 + b * 11) / 100;
            tl = tsum / 100;
            if (luma > tl + gt || luma < tl - gt)
                return 0;
        end
        if (ht >= 127 || (r == g && r == b) || (tgt_r == tgt_g && tgt_r == tgt_b))
            return 1;
        mid = crude_hue(tgt_r, tgt_g, tgt_b);
        h = crude_hue(r, g, b);
        up = to_sbyte(h + ht);
        down = to_sbyte(h - ht);
        if (up > down)
            return mid > down && mid < up;
        return mid > down || mid < up;
    endfunction

    function automatic logic [7:0] luma_scaled(input int c, input int psum, input int tsum);
        int v;
        v = (c * psum) / tsum;
        return (v > 255) ? 8'd255 : 8'(v);
    endfunction

    function automatic color_t predict_color(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
        color_t o;
        int tsum;
        int psum;
        tsum = 1 + tgt_r * 30 + tgt_g * 59 + tgt_b * 11;
        psum = 1 + r * 30 + g * 59 + b * 11;
        if (color_matches(r, g, b, tsum))
        begin
            o.r = luma_scaled(rep_r, psum, tsum);
            o.g = luma_scaled(rep_g, psum, tsum);
            o.b = luma_scaled(rep_b, psum, tsum);
            o.rep = 1'b1;
        end
        else
        begin
            o.r = r;
            o.g = g;
            o.b = b;
            o.rep = 1'b0;
        end
        return o;
    endfunction

    // Result side: random stalls, with one long hold-off on request.
    initial
    begin
        int gap;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 13);
            if (hold_long)
            begin
                gap = 200;
                hold_long = 0;
            end
            if (gap > 0)
            begin
                @(negedge clk);
                result_ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
                @(negedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        color_t w;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_colors.size() == 0)
            begin
                $display("%0t: result beat with nothing expected: %h %h %h %b", $time,
                         out_red, out_green, out_blue, replaced);
                errors++;
            end
            else
            begin
                w = pending_colors.pop_front();
                if (out_red !== w.r || out_green !== w.g || out_blue !== w.b ||
                    replaced !== w.rep)
                begin
                    $display("%0t: mismatch expected %h %h %h %b actual %h %h %h %b", $time,
                             w.r, w.g, w.b, w.rep, out_red, out_green, out_blue, replaced);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pixel_valid && pixel_ready) || (result_valid && result_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= 2000)
        begin
            $display("tolerant_color_replace regression: fail");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_TARGET_RED:        tgt_r = val;
            REG_TARGET_GREEN:      tgt_g = val;
            REG_TARGET_BLUE:       tgt_b = val;
            REG_REPLACEMENT_RED:   rep_r = val;
            REG_REPLACEMENT_GREEN: rep_g = val;
            REG_REPLACEMENT_BLUE:  rep_b = val;
            REG_GRAY_TOLERANCE:    gray_tol = val;
            default:               hue_tol = val[6:0];
        endcase
    endtask

    task automatic set_colors(input logic [7:0] tr, input logic [7:0] tg, input logic [7:0] tb,
                              input logic [7:0] pr, input logic [7:0] pg, input logic [7:0] pb,
                              input logic [7:0] gt, input logic [6:0] ht);
        // The last beat has been taken; stop offering it before draining.
        @(negedge clk);
        pixel_valid <= 1'b0;
        wait (pending_colors.size() == 0);
        repeat (10) @(posedge clk);
        write_reg(REG_TARGET_RED, tr);
        write_reg(REG_TARGET_GREEN, tg);
        write_reg(REG_TARGET_BLUE, tb);
        write_reg(REG_REPLACEMENT_RED, pr);
        write_reg(REG_REPLACEMENT_GREEN, pg);
        write_reg(REG_REPLACEMENT_BLUE, pb);
        write_reg(REG_GRAY_TOLERANCE, gt);
        write_reg(REG_HUE_TOLERANCE, {1'b0, ht});
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input bit typed, input color_t want);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        repeat (gap)
        begin
            @(negedge clk);
            pixel_valid <= 1'b0;
        end
        @(negedge clk);
        pixel_red <= r;
        pixel_green <= g;
        pixel_blue <= b;
        pixel_valid <= 1'b1;
        do @(posedge clk); while (!pixel_ready);
        pending_colors.push_back(typed ? want : predict_color(r, g, b));
    endtask

    function automatic logic [7:0] near(input logic [7:0] c);
        int v;
        v = int'(c) + $urandom_range(0, 40) - 20;
        return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
    endfunction

    task automatic random_pixels(input int n);
        logic [7:0] r, g, b;
        color_t none;
        none = '{default: 0};
        repeat (n)
        begin
            case ($urandom_range(0, 5))
                0, 1:
                begin
                    r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
                end
                2, 3:
                begin
                    r = near(tgt_r); g = near(tgt_g); b = near(tgt_b);
                end
                4:
                begin
                    r = 8'($urandom); g = r; b = r;
                end
                default:
                begin
                    r = 8'($urandom_range(0, 1) * 255);
                    g = 8'($urandom_range(0, 1) * 255);
                    b = 8'($urandom_range(0, 1) * 255);
                end
            endcase
            send_pixel(r, g, b, 0, none);
        end
    endtask

    pixel_row_t reset_rows[] = '{
        '{8'd0,   8'd0,   8'd0,   1, '{8'd0,   8'd0,   8'd0,   1'b1}},
        '{8'd255, 8'd255, 8'd255, 1, '{8'd255, 8'd255, 8'd255, 1'b0}},
        '{8'd255, 8'd0,   8'd0,   1, '{8'd255, 8'd0,   8'd0,   1'b0}},
        '{8'd0,   8'd255, 8'd0,   1, '{8'd0,   8'd255, 8'd0,   1'b0}},
        '{8'd0,   8'd0,   8'd255, 1, '{8'd0,   8'd0,   8'd255, 1'b0}},
        '{8'd1,   8'd1,   8'd1,   0, '{default: 0}},
        '{8'd3,   8'd0,   8'd0,   0, '{default: 0}},
        '{8'd10,  8'd20,  8'd30,  0, '{default: 0}},
        '{8'd30,  8'd20,  8'd10,  0, '{default: 0}},
        '{8'd20,  8'd30,  8'd10,  0, '{default: 0}},
        '{8'd20,  8'd10,  8'd30,  0, '{default: 0}},
        '{8'd10,  8'd30,  8'd20,  0, '{default: 0}},
        '{8'd30,  8'd10,  8'd20,  0, '{default: 0}},
        '{8'd170, 8'd85,  8'd0,   0, '{default: 0}},
        '{8'd0,   8'd85,  8'd170, 0, '{default: 0}}
    };

    initial
    begin
        int i;
        errors = 0;
        quiet_cycles = 0;
        hold_long = 0;
        no_idle = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pixel_valid = 1'b0;
        pixel_red = '0;
        pixel_green = '0;
        pixel_blue = '0;
        {tgt_r, tgt_g, tgt_b, rep_r, rep_g, rep_b, gray_tol} = '0;
        hue_tol = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // After reset every register is zero, so only pixels whose luma rounds down to zero match.
        foreach (reset_rows[i])
            send_pixel(reset_rows[i].r, reset_rows[i].g, reset_rows[i].b,
                       reset_rows[i].typed, reset_rows[i].want);

        // Both tolerances at their maximum: every pixel is replaced.
        set_colors(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 7'd127);
        random_pixels(20);
        set_colors(8'd200, 8'd50, 8'd30, 8'd10, 8'd200, 8'd90, 8'd40, 7'd20);
        random_pixels(30);
        // Luma check off, hue tolerance zero: the wrapped window takes every hue but the pixel's own.
        set_colors(8'd20, 8'd180, 8'd60, 8'd255, 8'd0, 8'd128, 8'd255, 7'd0);
        random_pixels(30);
        // Gray target waives the hue check.
        set_colors(8'd128, 8'd128, 8'd128, 8'd0, 8'd255, 8'd0, 8'd0, 7'd5);
        random_pixels(20);

        // Fill the pipe against a stalled receiver.
        no_idle = 1;
        hold_long = 1;
        random_pixels(30);
        no_idle = 0;

        for (i = 0; i < 9; i++)
        begin
            set_colors(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom),
                       ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(0, 80)),
                       ($urandom_range(0, 3) == 0) ? 7'd127 : 7'($urandom_range(0, 126)));
            no_idle = (i == 4);
            random_pixels(40);
        end
        no_idle = 0;

        @(negedge clk);
        pixel_valid <= 1'b0;
        wait (pending_colors.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("tolerant_color_replace regression: pass");
        else
            $display("tolerant_color_replace regression: fail");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/tcr_pkg.sv
rtl/tcr_hue_setup.sv
rtl/tolerant_color_replace.sv
test/tb_top.sv
